@@ src/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/bba_pkg.sv @@
// Package: types, codes and defaults of the bitmap block allocator.
package bba_pkg;

  localparam int MAX_BLOCKS_DEF = 4096;
  localparam int WORD_BITS_DEF  = 64;

  localparam int IDX_W     = 12;
  localparam int BLK_W     = 13;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] TOTAL_RESET = 13'd4096;
  localparam logic [CFG_W-1:0] FIRST_RESET = 13'd0;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST = 1'd1;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_DOUBLE  = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_FREE = 2'd2
  } state_t;

endpackage

@@ src/bitmap_block_allocator_unit.sv @@
// Top level of the first-free bitmap block allocator.
//
// Usage:
//   Command channel: drive kind and block_index with start high; the command
//   transaction is taken at a rising edge where start is high and busy is low.
//   kind selects allocate (lowest free block in [first_data_block, limit)) or
//   free (clear the bit of block_index).
//   Result channel: done pulses for one cycle with block_number and status;
//   the receiver cannot hold it off. Exactly one result per command.
//   Configuration: cfg_we with cfg_addr 0 (total_blocks) or 1
//   (first_data_block) and cfg_wdata; write only while the block is idle.
// Result paths:
//   Out-of-range free and empty-region allocate: result in the cycle after
//   accept, busy stays low. Free: result after one bitmap read.
//   Allocate: result once the scan ends, after N bitmap words scanned,
//   at most MAX_BLOCKS / WORD_BITS (64 at defaults); the scan reads one word
//   per cycle from the single-port-read bitmap RAM, which sets the rate.
// Reset: rst clears the state machine and the per-word valid bits, so the
//   whole bitmap reads free at once; no clearing pass is needed.
module bitmap_block_allocator_unit #(
  parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
  parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind,
  input  logic [bba_pkg::IDX_W-1:0]     block_index,
  input  logic                          cfg_we,
  input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [bba_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                          done,
  output logic [bba_pkg::IDX_W-1:0]     block_number,
  output bba_pkg::status_t              status
);
  import bba_pkg::*;

  localparam int NUM_WORDS = MAX_BLOCKS / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int OB        = $clog2(WORD_BITS);
  // Clamp the scan limit only when the store is smaller than the register range.
  localparam bit LIM_CLAMP = MAX_BLOCKS < (1 << BLK_W);
  localparam logic [BLK_W-1:0] MAX_LIM = BLK_W'(LIM_CLAMP ? MAX_BLOCKS : 0);

  state_t state;
  state_t state_next;

  logic [CFG_W-1:0] total_blocks;
  logic [CFG_W-1:0] first_data_block;

  logic [BLK_W-1:0] lim;
  logic [BLK_W-1:0] lim_m1;
  logic             alloc_ok;
  logic             free_ok;

  logic [AW-1:0] first_word;
  logic [AW-1:0] last_word;
  logic [AW-1:0] idx_word;
  logic [AW-1:0] chk_word;
  logic [AW-1:0] chk_word_next;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          at_first;
  logic          at_last;

  logic [NUM_WORDS-1:0] vld;
  logic                 rd_vld;
  logic                 we;

  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] word_now;
  logic [WORD_BITS-1:0] wdata;

  logic          found;
  logic [OB-1:0] pos;
  logic [BLK_W-1:0] found_blk;

  logic [IDX_W-1:0] idx_q;

  logic             done_next;
  logic [IDX_W-1:0] blk_next;
  status_t          status_next;

  // Scan limit and region checks, from stable configuration and the command index.
  assign lim      = (LIM_CLAMP && (total_blocks > MAX_LIM)) ? MAX_LIM : total_blocks;
  assign lim_m1   = lim - 1'b1;
  assign alloc_ok = first_data_block < lim;
  assign free_ok  = (BLK_W'(block_index) >= first_data_block) && (BLK_W'(block_index) < lim);

  assign first_word = AW'(first_data_block >> OB);
  assign last_word  = AW'(lim_m1 >> OB);
  assign idx_word   = AW'(block_index >> OB);
  assign at_first   = chk_word == first_word;
  assign at_last    = chk_word == last_word;

  // Words never written since reset read as all free.
  assign word_now  = rd_vld ? rdata : '0;
  assign found_blk = (BLK_W'(chk_word) << OB) | BLK_W'(pos);
  assign wr_addr   = chk_word;
  assign busy      = state != S_IDLE;

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wr_addr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  bba_find #(
    .WORD_BITS (WORD_BITS)
  ) u_find (
    .word   (word_now),
    .lo_en  (at_first),
    .lo_off (first_data_block[OB-1:0]),
    .hi_en  (at_last),
    .hi_off (lim_m1[OB-1:0]),
    .found  (found),
    .pos    (pos)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (kind == KIND_ALLOC && alloc_ok) begin
            state_next = S_SCAN;
          end else if (kind == KIND_FREE && free_ok) begin
            state_next = S_FREE;
          end
        end
      end
      S_SCAN: begin
        if (found || at_last) begin
          state_next = S_IDLE;
        end
      end
      S_FREE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Memory control and result.
  always_comb begin
    rd_addr       = AW'(chk_word + 1'b1);
    we            = 1'b0;
    wdata         = word_now;
    chk_word_next = chk_word;
    done_next     = 1'b0;
    blk_next      = '0;
    status_next   = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (kind == KIND_ALLOC) begin
            if (alloc_ok) begin
              rd_addr       = first_word;
              chk_word_next = first_word;
            end else begin
              done_next   = 1'b1;
              status_next = ST_NOSPACE;
            end
          end else begin
            if (free_ok) begin
              rd_addr       = idx_word;
              chk_word_next = idx_word;
            end else begin
              done_next   = 1'b1;
              status_next = ST_RANGE;
            end
          end
        end
      end
      S_SCAN: begin
        if (found) begin
          we        = 1'b1;
          wdata     = word_now | (WORD_BITS'(1) << pos);
          done_next = 1'b1;
          blk_next  = found_blk[IDX_W-1:0];
        end else if (at_last) begin
          done_next   = 1'b1;
          status_next = ST_NOSPACE;
        end else begin
          chk_word_next = AW'(chk_word + 1'b1);
        end
      end
      S_FREE: begin
        done_next = 1'b1;
        if (word_now[idx_q[OB-1:0]]) begin
          we       = 1'b1;
          wdata    = word_now & ~(WORD_BITS'(1) << idx_q[OB-1:0]);
          blk_next = idx_q;
        end else begin
          status_next = ST_DOUBLE;
        end
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  // Control registers and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      done             <= 1'b0;
      vld              <= '0;
      total_blocks     <= TOTAL_RESET;
      first_data_block <= FIRST_RESET;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (we) begin
        vld[wr_addr] <= 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_TOTAL: total_blocks     <= cfg_wdata;
          REG_FIRST: first_data_block <= cfg_wdata;
          default:   total_blocks     <= total_blocks;
        endcase
      end
    end
  end

  // Payload registers; hold the command index while a transaction is in flight.
  always_ff @(posedge clk) begin
    block_number <= blk_next;
    status       <= status_next;
    chk_word     <= chk_word_next;
    rd_vld       <= vld[rd_addr];
    if (state == S_IDLE) begin
      idx_q <= block_index;
    end
  end
endmodule

@@ src/bba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/bba_find.sv @@
// Lowest-free-bit finder over one bitmap word, with data-region edge masks.
module bba_find #(
  parameter int WORD_BITS = bba_pkg::WORD_BITS_DEF
) (
  input  logic [WORD_BITS-1:0]         word,
  input  logic                         lo_en,
  input  logic [$clog2(WORD_BITS)-1:0] lo_off,
  input  logic                         hi_en,
  input  logic [$clog2(WORD_BITS)-1:0] hi_off,
  output logic                         found,
  output logic [$clog2(WORD_BITS)-1:0] pos
);
  localparam int OB = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] used_bits;

  // Treat bits below the first data block and past the scan limit as used.
  assign lo_mask   = lo_en ? ~({WORD_BITS{1'b1}} << lo_off) : '0;
  assign hi_mask   = hi_en ? (({WORD_BITS{1'b1}} << hi_off) << 1) : '0;
  assign used_bits = word | lo_mask | hi_mask;

  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!used_bits[i]) begin
        found = 1'b1;
        pos   = OB'(i);
      end
    end
  end
endmodule

@@ src/bba_checker.sv @@
// Port-level checker for the bitmap block allocator, bound to the top level.
`include "assert_macros.svh"

module bba_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [bba_pkg::IDX_W-1:0]     block_number,
  input bba_pkg::status_t              status
);
  import bba_pkg::*;

  `ASSERT_NOW(a_err_zero, done && status != ST_OK, block_number == '0, "error result with nonzero block")
  `ASSERT_NEXT(a_accept_moves, start && !busy, busy || done, "accepted command neither busy nor answered")
  `ASSERT_NOW(a_fell_done, $fell(busy), done, "busy dropped without a result")
  `ASSERT_NOW(a_done_idle, done, !busy, "result shown while still busy")
endmodule

bind bitmap_block_allocator_unit bba_checker u_bba_checker (.*);

@@ bench/bitmap_block_allocator_unit_test.sv @@
// Self-checking bench for the bitmap block allocator: directed corners, then random phases.
`timescale 1ns / 1ps

module bitmap_block_allocator_unit_test;
  import bba_pkg::*;

  // One expected result transaction: the block number and the status code.
  typedef struct packed {
    logic [IDX_W-1:0] blk;
    status_t          st;
  } outcome_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 kind = KIND_ALLOC;
  logic [IDX_W-1:0]     block_index = '0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = REG_TOTAL;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 busy;
  logic                 done;
  logic [IDX_W-1:0]     block_number;
  status_t              status;

  // Shadow copy of the allocator: used bits and both registers.
  bit                   used_map [0:MAX_BLOCKS_DEF-1];
  logic [CFG_W-1:0]     shadow_total;
  logic [CFG_W-1:0]     shadow_first;
  int                   high_mark;

  // Results still owed by the block, oldest first.
  outcome_t             owed_results [$];
  int                   error_count = 0;
  int                   idle_pct = 0;

  bitmap_block_allocator_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .block_index (block_index),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .done        (done),
    .block_number(block_number),
    .status      (status)
  );

  always #5 clk = ~clk;

  // Effective scan limit: total_blocks saturates at the size of the store.
  function automatic int scan_limit();
    return (int'(shadow_total) > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : int'(shadow_total);
  endfunction

  // Compute the result of one request and update the shadow bitmap.
  function automatic outcome_t apply_request(logic k, logic [IDX_W-1:0] idx);
    int       lim;
    int       first;
    int       b;
    outcome_t r;
    lim   = scan_limit();
    first = int'(shadow_first);
    r.blk = '0;
    if (k == KIND_ALLOC) begin
      // First-free scan from the bottom of the data region.
      r.st = ST_NOSPACE;
      for (b = first; b < lim; b++) begin
        if (!used_map[b]) begin
          used_map[b] = 1'b1;
          r.blk = IDX_W'(b);
          r.st  = ST_OK;
          if (b > high_mark) high_mark = b;
          break;
        end
      end
    end else begin
      // Metadata blocks and blocks past the limit are out of range.
      if (int'(idx) < first || int'(idx) >= lim) begin
        r.st = ST_RANGE;
      end else if (!used_map[idx]) begin
        r.st = ST_DOUBLE;
      end else begin
        used_map[idx] = 1'b0;
        r.blk = idx;
        r.st  = ST_OK;
      end
    end
    return r;
  endfunction

  // Result checker: every done pulse must match the oldest owed result.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && done) begin
      if (owed_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, block_number %0d status %0d",
                 $realtime, block_number, status);
      end else begin
        want = owed_results.pop_front();
        if (block_number !== want.blk) begin
          error_count++;
          $display("%0t: block_number expected %0d actual %0d",
                   $realtime, want.blk, block_number);
        end
        if (status !== want.st) begin
          error_count++;
          $display("%0t: status expected %0d actual %0d", $realtime, want.st, status);
        end
      end
    end
  end

  // Hold one command until it is taken; leave start high for a following one.
  task automatic issue_request(logic k, logic [IDX_W-1:0] idx);
    start       <= 1'b1;
    kind        <= k;
    block_index <= idx;
    do @(posedge clk); while (busy);
    owed_results.push_back(apply_request(k, idx));
    // Insert random sender gaps after the transaction.
    while ($urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drop start and hold until every owed result has come back.
  task automatic drain_results();
    if (start) start <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  // Registers change only while idle: drain, then let the pipeline settle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] addr, int value);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= CFG_W'(value);
    @(posedge clk);
    if (addr == REG_TOTAL) shadow_total = CFG_W'(value);
    else shadow_first = CFG_W'(value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Pick a free target: mostly live blocks, sometimes edges, sometimes noise.
  function automatic logic [IDX_W-1:0] pick_free_target();
    int lim;
    int first;
    int hi;
    int idx;
    int roll;
    lim   = scan_limit();
    first = int'(shadow_first);
    hi    = (high_mark + 2 < lim) ? high_mark + 2 : lim;
    roll  = $urandom_range(0, 99);
    idx   = $urandom_range(0, MAX_BLOCKS_DEF - 1);
    if (roll < 70 && hi > first) begin
      for (int t = 0; t < 8; t++) begin
        idx = $urandom_range(first, hi - 1);
        if (used_map[idx]) break;
      end
    end else if (roll < 85) begin
      case ($urandom_range(0, 3))
        0: idx = first - 1;
        1: idx = first;
        2: idx = lim - 1;
        default: idx = lim;
      endcase
      if (idx < 0) idx = 0;
      if (idx > MAX_BLOCKS_DEF - 1) idx = MAX_BLOCKS_DEF - 1;
    end
    return IDX_W'(idx);
  endfunction

  task automatic random_request(int alloc_pct);
    if ($urandom_range(1, 100) <= alloc_pct)
      issue_request(KIND_ALLOC, IDX_W'($urandom_range(0, MAX_BLOCKS_DEF - 1)));
    else
      issue_request(KIND_FREE, pick_free_target());
  endtask

  // Reset defaults: block zero, double free, and all index bits.
  task automatic test_reset_defaults();
    issue_request(KIND_ALLOC, 12'h000);
    issue_request(KIND_ALLOC, 12'hFFF);
    issue_request(KIND_FREE, 12'h000);
    issue_request(KIND_FREE, 12'h000);
    issue_request(KIND_FREE, 12'hFFF);
    issue_request(KIND_ALLOC, 12'h000);
    issue_request(KIND_FREE, 12'hAAA);
    issue_request(KIND_FREE, 12'h555);
  endtask

  // Register corners: saturated limit, empty region, stranded metadata bits.
  task automatic test_register_corners();
    write_reg(REG_TOTAL, 8191);
    issue_request(KIND_FREE, 12'hFFF);
    issue_request(KIND_ALLOC, 12'h000);
    write_reg(REG_TOTAL, 3);
    issue_request(KIND_ALLOC, 12'h000);
    issue_request(KIND_ALLOC, 12'h000);
    issue_request(KIND_FREE, 12'h003);
    // Raise the metadata boundary over used blocks; they stay stranded.
    write_reg(REG_FIRST, 2);
    issue_request(KIND_FREE, 12'h001);
    issue_request(KIND_FREE, 12'h000);
    issue_request(KIND_ALLOC, 12'h000);
    write_reg(REG_FIRST, 3);
    issue_request(KIND_ALLOC, 12'h000);
    issue_request(KIND_FREE, 12'h002);
    write_reg(REG_TOTAL, 0);
    issue_request(KIND_ALLOC, 12'h000);
    issue_request(KIND_FREE, 12'h000);
    write_reg(REG_TOTAL, 4096);
    write_reg(REG_FIRST, 4096);
    issue_request(KIND_ALLOC, 12'h000);
    issue_request(KIND_FREE, 12'hFFF);
    // Top word only: the last block of the store.
    write_reg(REG_FIRST, 4095);
    issue_request(KIND_ALLOC, 12'h000);
    issue_request(KIND_ALLOC, 12'h000);
    issue_request(KIND_FREE, 12'hFFF);
    write_reg(REG_FIRST, 8191);
    issue_request(KIND_ALLOC, 12'h000);
    write_reg(REG_TOTAL, 1);
    write_reg(REG_FIRST, 0);
    issue_request(KIND_ALLOC, 12'h000);
    issue_request(KIND_FREE, 12'h000);
  endtask

  // Sender pauses until the block has returned everything owed.
  task automatic test_drain_pauses();
    write_reg(REG_TOTAL, 96);
    write_reg(REG_FIRST, 8);
    idle_pct = 0;
    repeat (6) begin
      random_request(60);
      drain_results();
    end
  endtask

  // Random phases over several register settings and idle profiles.
  task automatic test_random_phases();
    int ph_total [9] = '{4096, 40, 8191, 130, 1, 4096, 200, 8191, 0};
    int ph_first [9] = '{0, 0, 4000, 64, 0, 4090, 150, 4096, 0};
    int ph_alloc [9] = '{55, 75, 60, 70, 60, 65, 70, 50, 60};
    int idle_mode [4] = '{0, 57, 0, 33};
    int tot;
    for (int p = 0; p < 9; p++) begin
      tot = ph_total[p];
      if (p == 8) tot = $urandom_range(1, 4096);
      write_reg(REG_TOTAL, tot);
      write_reg(REG_FIRST, (p == 8) ? $urandom_range(0, tot - 1) : ph_first[p]);
      idle_pct = idle_mode[p % 4];
      repeat (60) random_request(ph_alloc[p]);
    end
  endtask

  initial begin
    for (int i = 0; i < MAX_BLOCKS_DEF; i++) used_map[i] = 1'b0;
    shadow_total = TOTAL_RESET;
    shadow_first = FIRST_RESET;
    high_mark    = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_register_corners();
    test_drain_pauses();
    test_random_phases();

    // Drain, then watch for stray results over a full scan time.
    drain_results();
    repeat (80) @(posedge clk);
    if (error_count == 0)
      $display("bitmap_block_allocator_unit: match");
    else
      $display("bitmap_block_allocator_unit: mismatch");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("bitmap_block_allocator_unit: mismatch");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/bba_pkg.sv
src/bba_ram.sv
src/bba_find.sv
src/bitmap_block_allocator_unit.sv
src/bba_checker.sv
bench/bitmap_block_allocator_unit_test.sv
